// ===== design/weighted_sorted_request_queues_unit_assert.svh =====
// Assertion macros for the weighted sorted request queues unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef WEIGHTED_SORTED_REQUEST_QUEUES_UNIT_ASSERT_SVH
`define WEIGHTED_SORTED_REQUEST_QUEUES_UNIT_ASSERT_SVH

// same-cycle implication
`define WSRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wsrq_pkg.sv =====
// Types and constants of the weighted sorted request queues unit.
// No dependencies.
`default_nettype none
package wsrq_pkg;

    localparam int unsigned NUM_CAP = 4;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] prio;
        logic [9:0]  weight;
    } entry_t;

endpackage
`default_nettype wire

// ===== design/wsrq_ifs.sv =====
// Handshake channels of the unit: request, response and register write.
// Depends on nothing.
`default_nettype none
interface wsrq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  queue_sel;
    logic [7:0]  requester_id;
    logic [31:0] request_priority;
    logic [9:0]  request_weight;
    modport source (output valid, req_type, queue_sel, requester_id, request_priority,
                    request_weight, input ready);
    modport sink (input valid, req_type, queue_sel, requester_id, request_priority,
                  request_weight, output ready);
endinterface

interface wsrq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  position;
    logic [15:0] weight_ahead;
    logic        is_last_fitting;
    logic [6:0]  occupancy;
    modport source (output valid, status, position, weight_ahead, is_last_fitting,
                    occupancy, input ready);
    modport sink (input valid, status, position, weight_ahead, is_last_fitting,
                  occupancy, output ready);
endinterface

interface wsrq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  wr_index;
    logic [15:0] wr_data;
    modport source (output valid, wr_index, wr_data, input ready);
    modport sink (input valid, wr_index, wr_data, output ready);
endinterface
`default_nettype wire

// ===== design/wsrq_entry_ram.sv =====
// Entry store for all queues: one write port, one registered read port.
// Depends on wsrq_pkg.
`default_nettype none
module wsrq_entry_ram
    import wsrq_pkg::*;
#(
    parameter int unsigned ENTRIES = 256,
    parameter int unsigned AW      = 8
)(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);
    entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== design/weighted_sorted_request_queues_unit.sv =====
// Top level of the weighted sorted request queues unit.
// Depends on wsrq_pkg, wsrq_ifs, wsrq_entry_ram and the assertion header.
//
//  channel  | dir | words carried
//  req_ch   | in  | insert / remove / query request
//  rsp_ch   | out | status, position, weight ahead, fit flag, occupancy
//  cfg_ch   | in  | capacity register write, always ready
//
// One request at a time. A request walks its queue through the single read port
// of the entry store: a search pass, a shift when an insert or remove goes ahead,
// a write of the new entry on an insert, a result pass and the output load, in
// that order. The unit goes back to idle before it takes the next request.
// A bad queue number skips the passes and goes straight to the output load.
// Reset clears fill counts and capacities; the entry store is not cleared.
// A waiting response holds the unit in its final state until taken.
`default_nettype none
`include "weighted_sorted_request_queues_unit_assert.svh"
module weighted_sorted_request_queues_unit
    import wsrq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned NUM_QUEUES  = 4
)(
    input wire logic  clk,
    input wire logic  rst_n,
    wsrq_req_if.sink  req_ch,
    wsrq_rsp_if.source rsp_ch,
    wsrq_cfg_if.sink  cfg_ch
);
    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned SW = IW + 10;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN1 = 6'b000010,
        S_SHIFT = 6'b000100,
        S_WRNEW = 6'b001000,
        S_SCAN2 = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t          st_reg, st_next;
    logic [1:0]      type_reg, type_next;
    logic [1:0]      q_reg, q_next;
    logic [7:0]      id_reg, id_next;
    logic [31:0]     prio_reg, prio_next;
    logic [9:0]      w_reg, w_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pend_reg, pend_next;
    logic [CW-1:0]   pidx_reg, pidx_next;
    logic            found_reg, found_next;
    logic [CW-1:0]   fpos_reg, fpos_next;
    logic [CW-1:0]   at_reg, at_next;
    status_t         status_reg, status_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [9:0]      wpos_reg, wpos_next;
    logic [9:0]      wnext_reg, wnext_next;
    logic            hasnext_reg, hasnext_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_status_reg;
    logic [5:0]      out_pos_reg;
    logic [15:0]     out_ahead_reg;
    logic            out_last_reg;
    logic [6:0]      out_occ_reg;
    logic            out_load;

    logic [CW-1:0]   fill_reg [NUM_QUEUES];
    logic            fill_we;
    logic [CW-1:0]   fill_wdata;
    logic [15:0]     cap_reg [NUM_CAP];

    logic            rd_en, wr_en;
    logic [CW-1:0]   rd_idx, wr_idx;
    logic [AW-1:0]   base, rd_addr, wr_addr;
    entry_t          rd_data, wr_data;

    logic            req_fire, is_less, is_insert;
    logic [SW+15:0]  sum_ext;
    logic [SW:0]     fit_sum;
    logic [15:0]     cap_q;

    assign req_ch.ready = (st_reg == S_IDLE);
    assign req_fire     = req_ch.valid && req_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign is_insert    = (type_reg == REQ_INSERT);

    assign base    = AW'(AW'(q_reg) * AW'(QUEUE_DEPTH));
    assign rd_addr = base + AW'(rd_idx[IW-1:0]);
    assign wr_addr = base + AW'(wr_idx[IW-1:0]);

    assign is_less = (rd_data.prio < prio_reg) ||
                     ((rd_data.prio == prio_reg) && (rd_data.id < id_reg));

    assign cap_q   = cap_reg[q_reg];
    assign sum_ext = (SW + 16)'(sum_reg);
    assign fit_sum = (SW + 1)'(sum_reg) + (SW + 1)'(wpos_reg) + (SW + 1)'(wnext_reg);

    wsrq_entry_ram #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        st_next      = st_reg;
        type_next    = type_reg;
        q_next       = q_reg;
        id_next      = id_reg;
        prio_next    = prio_reg;
        w_next       = w_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        found_next   = found_reg;
        fpos_next    = fpos_reg;
        at_next      = at_reg;
        status_next  = status_reg;
        sum_next     = sum_reg;
        wpos_next    = wpos_reg;
        wnext_next   = wnext_reg;
        hasnext_next = hasnext_reg;
        fill_we      = 1'b0;
        fill_wdata   = n_reg;
        rd_en        = 1'b0;
        rd_idx       = cnt_reg;
        wr_en        = 1'b0;
        wr_idx       = pidx_reg;
        wr_data      = rd_data;
        out_load     = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ch.ready;

        case (st_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    type_next   = req_ch.req_type;
                    q_next      = req_ch.queue_sel;
                    id_next     = req_ch.requester_id;
                    prio_next   = req_ch.request_priority;
                    w_next      = req_ch.request_weight;
                    cnt_next    = '0;
                    found_next  = 1'b0;
                    fpos_next   = '0;
                    at_next     = '0;
                    status_next = ST_OK;
                    if (32'(req_ch.queue_sel) >= NUM_QUEUES)
                    begin
                        status_next = ST_NOT_FOUND;
                        n_next      = '0;
                        st_next     = S_DONE;
                    end
                    else
                    begin
                        n_next  = fill_reg[req_ch.queue_sel[QW-1:0]];
                        st_next = S_SCAN1;
                    end
                end
            end

            S_SCAN1:
            begin
                if (cnt_reg < n_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (!found_reg && (rd_data.id == id_reg))
                    begin
                        found_next = 1'b1;
                        fpos_next  = pidx_reg;
                    end
                    if (is_less)
                    begin
                        at_next = at_reg + 1'b1;
                    end
                end
                if (!(cnt_reg < n_reg) && !pend_reg)
                begin
                    // decide the request once the whole queue is seen
                    st_next      = S_SCAN2;
                    cnt_next     = '0;
                    found_next   = 1'b0;
                    fpos_next    = '0;
                    sum_next     = '0;
                    hasnext_next = 1'b0;
                    if (type_reg == REQ_INSERT)
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_DUPLICATE;
                        end
                        else if (32'(n_reg) >= QUEUE_DEPTH)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            fill_we    = 1'b1;
                            fill_wdata = n_reg + 1'b1;
                            cnt_next   = n_reg;
                            st_next    = S_SHIFT;
                        end
                    end
                    else if (type_reg == REQ_REMOVE)
                    begin
                        if (found_reg)
                        begin
                            fill_we    = 1'b1;
                            fill_wdata = n_reg - 1'b1;
                            cnt_next   = fpos_reg + 1'b1;
                            st_next    = S_SHIFT;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    else if (!found_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
            end

            S_SHIFT:
            begin
                // read one entry, write it one slot over in the next cycle
                if (is_insert && (cnt_reg > at_reg))
                begin
                    rd_en     = 1'b1;
                    rd_idx    = cnt_reg - 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                    cnt_next  = cnt_reg - 1'b1;
                end
                else if (!is_insert && (cnt_reg < n_reg))
                begin
                    rd_en     = 1'b1;
                    rd_idx    = cnt_reg;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg - 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                end
                if (!rd_en && !pend_reg)
                begin
                    if (is_insert)
                    begin
                        st_next = S_WRNEW;
                    end
                    else
                    begin
                        st_next  = S_SCAN2;
                        n_next   = n_reg - 1'b1;
                        cnt_next = '0;
                    end
                end
            end

            S_WRNEW:
            begin
                wr_en    = 1'b1;
                wr_idx   = at_reg;
                wr_data  = '{id: id_reg, prio: prio_reg, weight: w_reg};
                n_next   = n_reg + 1'b1;
                cnt_next = '0;
                st_next  = S_SCAN2;
            end

            S_SCAN2:
            begin
                if (cnt_reg < n_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (!found_reg)
                    begin
                        if (rd_data.id == id_reg)
                        begin
                            found_next = 1'b1;
                            fpos_next  = pidx_reg;
                            wpos_next  = rd_data.weight;
                        end
                        else
                        begin
                            sum_next = sum_reg + SW'(rd_data.weight);
                        end
                    end
                    else if (pidx_reg == fpos_reg + 1'b1)
                    begin
                        hasnext_next = 1'b1;
                        wnext_next   = rd_data.weight;
                    end
                end
                if (!(cnt_reg < n_reg) && !pend_reg)
                begin
                    st_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    st_next        = S_IDLE;
                end
            end

            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                fill_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_CAP; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg        <= st_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (fill_we)
            begin
                fill_reg[q_reg[QW-1:0]] <= fill_wdata;
            end
            if (cfg_ch.valid)
            begin
                cap_reg[cfg_ch.wr_index] <= cfg_ch.wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        q_reg       <= q_next;
        id_reg      <= id_next;
        prio_reg    <= prio_next;
        w_reg       <= w_next;
        n_reg       <= n_next;
        cnt_reg     <= cnt_next;
        pidx_reg    <= pidx_next;
        found_reg   <= found_next;
        fpos_reg    <= fpos_next;
        at_reg      <= at_next;
        status_reg  <= status_next;
        sum_reg     <= sum_next;
        wpos_reg    <= wpos_next;
        wnext_reg   <= wnext_next;
        hasnext_reg <= hasnext_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_occ_reg    <= 7'(n_reg);
            if (found_reg)
            begin
                out_pos_reg   <= 6'(fpos_reg);
                out_ahead_reg <= (sum_ext > (SW + 16)'(16'hFFFF)) ? 16'hFFFF
                                                                 : sum_ext[15:0];
                out_last_reg  <= !hasnext_reg || (fit_sum > (SW + 1)'(cap_q));
            end
            else
            begin
                out_pos_reg   <= '0;
                out_ahead_reg <= '0;
                out_last_reg  <= 1'b0;
            end
        end
    end

    assign rsp_ch.valid           = out_valid_reg;
    assign rsp_ch.status          = out_status_reg;
    assign rsp_ch.position        = out_pos_reg;
    assign rsp_ch.weight_ahead    = out_ahead_reg;
    assign rsp_ch.is_last_fitting = out_last_reg;
    assign rsp_ch.occupancy       = out_occ_reg;

    `WSRQ_ASSERT_NOW(a_no_write_in_scan, (st_reg == S_SCAN1) || (st_reg == S_SCAN2), !wr_en, "store written during a scan")
    `WSRQ_ASSERT_NOW(a_fill_bound, st_reg != S_IDLE, 32'(n_reg) <= QUEUE_DEPTH, "fill count beyond queue depth")
    `WSRQ_ASSERT_NEXT(a_bad_queue, req_fire && (32'(req_ch.queue_sel) >= NUM_QUEUES), st_reg == S_DONE, "bad queue number not answered at once")
    `WSRQ_ASSERT_NOW(a_load_room, out_load, !out_valid_reg || rsp_ch.ready, "response word overwritten")
endmodule
`default_nettype wire
